[sv/tbd_pkg.sv]
// Shared types, constants and round schedule for the TEA block decryptor.
`default_nettype none

package tbd_pkg;

	// Cipher geometry.
	localparam int unsigned ROUNDS    = 32;
	localparam int unsigned CELLS     = 2 * ROUNDS;
	localparam int unsigned WORD_W    = 32;
	localparam int unsigned ADDR_W    = 4;
	localparam logic [31:0] TEA_DELTA = 32'h9E37_79B9;

	// Key register indexes on the configuration port.
	localparam logic [1:0] REG_KEY0 = 2'd0;
	localparam logic [1:0] REG_KEY1 = 2'd1;
	localparam logic [1:0] REG_KEY2 = 2'd2;
	localparam logic [1:0] REG_KEY3 = 2'd3;

	// Data handed from one cell to the next: x feeds the mix, y is updated.
	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
	} lane_t;

	// The 128-bit key as four words.
	typedef struct packed {
		logic [WORD_W-1:0] k3;
		logic [WORD_W-1:0] k2;
		logic [WORD_W-1:0] k1;
		logic [WORD_W-1:0] k0;
	} key_t;

	// Running sum seen by half-round cell c: delta times the rounds still to go.
	function automatic logic [WORD_W-1:0] cell_sum(input int unsigned c);
		logic [63:0] prod;
		prod = 64'(TEA_DELTA) * 64'(ROUNDS - (c >> 1));
		return prod[WORD_W-1:0];
	endfunction

endpackage

`default_nettype wire

[sv/tea_block_decrypt.sv]
// TEA block decryptor: APB key registers, a chain of half-round cells, output queue.
//
// Usage:
// - Ciphertext enters on cipher_first/cipher_second with cipher_valid and
//   cipher_ready; a transaction completes when both are high at a clock edge.
// - Plaintext leaves on plain_first/plain_second with plain_valid and
//   plain_ready under the same rule, in the order the blocks came in.
// - The key lives in four APB registers at byte addresses 0, 4, 8 and 12.
//   Write them only while no block is in flight.
// - Each of the 64 cells performs one half-round and registers its result;
//   a block passes through the 64 cell registers, is then written into the
//   output queue and can leave from there.
// - Throughput is one block per cycle while the output queue has room: every
//   cell hands its data on each cycle that the chain advances.
// - The chain advances while the two-entry output queue has room. When the
//   receiver stalls, one more result is absorbed and then cipher_ready drops
//   until plain_ready returns.
// - Reset sets the key to 1, 2, 3, 4 and empties the chain and the queue.
`default_nettype none

module tea_block_decrypt (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cipher_valid,
	output logic                            cipher_ready,
	input  wire logic [31:0]                cipher_first,
	input  wire logic [31:0]                cipher_second,
	output logic                            plain_valid,
	input  wire logic                       plain_ready,
	output logic [31:0]                     plain_first,
	output logic [31:0]                     plain_second,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [tbd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready
);

	tbd_pkg::key_t  key;
	tbd_pkg::lane_t lane [tbd_pkg::CELLS+1];
	logic           en;

	// Key registers.
	tbd_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.key     (key)
	);

	// Head of the chain: left word mixes first, right word is updated first.
	assign cipher_ready = en;
	assign lane[0]      = '{valid: cipher_valid, x: cipher_first, y: cipher_second};

	// Even cells update the right word with k2/k3, odd cells the left with k0/k1.
	for (genvar c = 0; c < tbd_pkg::CELLS; c++) begin : g_cell
		tbd_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.sum      (tbd_pkg::cell_sum(c)),
			.ka       ((c % 2 == 0) ? key.k2 : key.k0),
			.kb       ((c % 2 == 0) ? key.k3 : key.k1),
			.lane_in  (lane[c]),
			.lane_out (lane[c+1])
		);
	end

	// After an even number of swaps x holds the left word again.
	tbd_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (en && lane[tbd_pkg::CELLS].valid),
		.push_first  (lane[tbd_pkg::CELLS].x),
		.push_second (lane[tbd_pkg::CELLS].y),
		.not_full    (en),
		.head_valid  (plain_valid),
		.pop_ready   (plain_ready),
		.head_first  (plain_first),
		.head_second (plain_second)
	);

endmodule

`default_nettype wire

[sv/tbd_cell.sv]
// One half-round of TEA decryption with its pipeline register.
`default_nettype none

module tbd_cell (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       en,
	input  wire logic [tbd_pkg::WORD_W-1:0] sum,
	input  wire logic [tbd_pkg::WORD_W-1:0] ka,
	input  wire logic [tbd_pkg::WORD_W-1:0] kb,
	input  wire tbd_pkg::lane_t             lane_in,
	output tbd_pkg::lane_t                  lane_out
);

	logic [tbd_pkg::WORD_W-1:0] mix;
	logic [tbd_pkg::WORD_W-1:0] y_new;
	logic                       valid_s1;
	logic [tbd_pkg::WORD_W-1:0] x_s1;
	logic [tbd_pkg::WORD_W-1:0] y_s1;

	// TEA mixing function applied to x, then subtracted from y.
	always_comb begin
		mix   = ((lane_in.x << 4) + ka) ^ (lane_in.x + sum) ^ ((lane_in.x >> 5) + kb);
		y_new = lane_in.y - mix;
	end

	// Valid bit is control state and is reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= lane_in.valid;
		end
	end

	// The updated word mixes in the next cell, so the two words swap places.
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= y_new;
			y_s1 <= lane_in.x;
		end
	end

	assign lane_out = '{valid: valid_s1, x: x_s1, y: y_s1};

endmodule

`default_nettype wire

[sv/tbd_outq.sv]
// Two-entry output queue that lets the cell chain run while a result waits.
`default_nettype none

module tbd_outq (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       push,
	input  wire logic [tbd_pkg::WORD_W-1:0] push_first,
	input  wire logic [tbd_pkg::WORD_W-1:0] push_second,
	output logic                            not_full,
	output logic                            head_valid,
	input  wire logic                       pop_ready,
	output logic [tbd_pkg::WORD_W-1:0]      head_first,
	output logic [tbd_pkg::WORD_W-1:0]      head_second
);

	logic [tbd_pkg::WORD_W-1:0] first_q  [2];
	logic [tbd_pkg::WORD_W-1:0] second_q [2];
	logic                       wptr_q;
	logic                       rptr_q;
	logic [1:0]                 count_q;
	logic                       pop;

	assign head_valid  = (count_q != 2'd0);
	assign not_full    = (count_q != 2'd2);
	assign pop         = head_valid && pop_ready;
	assign head_first  = first_q[rptr_q];
	assign head_second = second_q[rptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= 1'b0;
			rptr_q  <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= ~wptr_q;
			end
			if (pop) begin
				rptr_q <= ~rptr_q;
			end
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Result storage.
	always_ff @(posedge clk) begin
		if (push) begin
			first_q[wptr_q]  <= push_first;
			second_q[wptr_q] <= push_second;
		end
	end

endmodule

`default_nettype wire

[sv/tbd_cfg.sv]
// APB register file holding the four key words.
`default_nettype none

module tbd_cfg (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [tbd_pkg::ADDR_W-1:0] paddr,
	input  wire logic [31:0]                pwdata,
	output logic [31:0]                     prdata,
	output logic                            pready,
	output tbd_pkg::key_t                   key
);

	tbd_pkg::key_t key_q;
	logic          wr;
	logic [1:0]    idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[3:2];
	assign key    = key_q;

	// Key writes; reset key is 1, 2, 3, 4.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q.k0 <= 32'd1;
			key_q.k1 <= 32'd2;
			key_q.k2 <= 32'd3;
			key_q.k3 <= 32'd4;
		end else if (wr) begin
			unique case (idx)
				tbd_pkg::REG_KEY0: key_q.k0 <= pwdata;
				tbd_pkg::REG_KEY1: key_q.k1 <= pwdata;
				tbd_pkg::REG_KEY2: key_q.k2 <= pwdata;
				tbd_pkg::REG_KEY3: key_q.k3 <= pwdata;
			endcase
		end
	end

	// Read-back of the addressed key word.
	always_comb begin
		unique case (idx)
			tbd_pkg::REG_KEY0: prdata = key_q.k0;
			tbd_pkg::REG_KEY1: prdata = key_q.k1;
			tbd_pkg::REG_KEY2: prdata = key_q.k2;
			tbd_pkg::REG_KEY3: prdata = key_q.k3;
		endcase
	end

endmodule

`default_nettype wire

[sv/tbd_checker.sv]
// Port-level checks for the TEA block decryptor, bound to the top level.
`default_nettype none

module tbd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        cipher_ready,
	input wire logic        plain_valid,
	input wire logic        plain_ready,
	input wire logic [31:0] plain_first,
	input wire logic [31:0] plain_second,
	input wire logic        pready
);

	// The APB port never inserts wait states.
	a_pready_high: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready is low");

	// Input is held off only while results are waiting.
	a_stall_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		!cipher_ready |-> plain_valid)
		else $error("cipher_ready low with no pending result");

	// Input backpressure starts only after the receiver has refused a result.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(cipher_ready) |-> $past(plain_valid && !plain_ready))
		else $error("cipher_ready fell without an output stall");

	// A refused result stays offered with the same value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		plain_valid && !plain_ready |=> plain_valid && $stable(plain_first)
			&& $stable(plain_second))
		else $error("stalled result changed or was dropped");

endmodule

bind tea_block_decrypt tbd_checker u_tbd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.cipher_ready (cipher_ready),
	.plain_valid  (plain_valid),
	.plain_ready  (plain_ready),
	.plain_first  (plain_first),
	.plain_second (plain_second),
	.pready       (pready)
);

`default_nettype wire
